// ----- rtl/etot_pkg.sv -----
`timescale 1ns / 1ps

package etot_pkg;

  // Sequencer states of the totient engine
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_REST_WAIT,
    ST_REST_GO,
    ST_ACC_GO,
    ST_ACC_WAIT,
    ST_TAIL_WAIT,
    ST_DONE
  } etot_state_t;

endpackage

// ----- rtl/etot_div.sv -----
`timescale 1ns / 1ps

// Radix-2 restoring divider, one quotient bit per cycle.
// Divisor must be nonzero. done pulses one cycle with quo/rem valid.
module etot_div #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quo,
  output logic [WIDTH-1:0] rem
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             ge;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    shifted = {rem, quo[WIDTH-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = !diff[WIDTH];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo <= {quo[WIDTH-2:0], ge};
    end
  end

  // Remainder stays below the divisor once a division completes
  a_rem_lt_dvs: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dvs))
    else $error("divider remainder not below divisor");

  // No restart while a division is running
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("divider started while busy");

  // done only follows a running division
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

// ----- rtl/euler_totient_core.sv -----
`timescale 1ns / 1ps

// Euler totient engine.
// Input channel: value with in_valid/in_ready. Output channel: totient with
// out_valid/out_ready. One result transaction per input transaction.
// phi(m) is formed by trial division: for p = 2, 3, ... while p*p <= rest,
// p is divided out of rest and acc -= acc / p once per prime factor found;
// a leftover rest > 1 is a last prime factor. m = 0 gives 0, m = 1 gives 1.
// All divisions go through one shared radix-2 divider; p*p is kept as a
// running square (adder only). The worst case is a prime m near 2^WIDTH,
// with about 2^(WIDTH/2) trial divisors. One item is worked at a time;
// in_ready is high only while the engine is idle.
// The result sits in an output register until taken; while the receiver
// stalls, a finished item waits in the done state and no new item enters.
// Reset (rst, synchronous) returns the engine to idle and drops out_valid.
module euler_totient_core #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] totient
);

  import etot_pkg::*;

  etot_state_t      state, state_next;
  logic [WIDTH-1:0] rest;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] p;
  logic [WIDTH+1:0] sq;
  logic             hit;

  logic             div_start;
  logic [WIDTH-1:0] div_dividend;
  logic [WIDTH-1:0] div_divisor;
  logic             div_done;
  logic [WIDTH-1:0] div_quo;
  logic [WIDTH-1:0] div_rem;

  logic             sq_over;
  logic             out_free;

  assign sq_over  = sq > {2'b00, rest};
  assign out_free = !out_valid || out_ready;

  etot_div #(.WIDTH(WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_TEST;
      ST_TEST: begin
        if (!sq_over) begin
          state_next = ST_REST_WAIT;
        end else if (rest > WIDTH'(1)) begin
          state_next = ST_TAIL_WAIT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_REST_WAIT: begin
        if (div_done) begin
          if (div_rem == '0) begin
            state_next = ST_REST_GO;
          end else if (hit) begin
            state_next = ST_ACC_GO;
          end else begin
            state_next = ST_TEST;
          end
        end
      end
      ST_REST_GO:   state_next = ST_REST_WAIT;
      ST_ACC_GO:    state_next = ST_ACC_WAIT;
      ST_ACC_WAIT:  if (div_done) state_next = ST_TEST;
      ST_TAIL_WAIT: if (div_done) state_next = ST_DONE;
      ST_DONE:      if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and divider launch
  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = rest;
    div_divisor  = p;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_TEST: begin
        if (!sq_over) begin
          div_start = 1'b1;
        end else if (rest > WIDTH'(1)) begin
          div_start    = 1'b1;
          div_dividend = acc;
          div_divisor  = rest;
        end
      end
      ST_REST_GO: div_start = 1'b1;
      ST_ACC_GO: begin
        div_start    = 1'b1;
        div_dividend = acc;
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          rest <= value;
          acc  <= value;
          p    <= WIDTH'(2);
          sq   <= (WIDTH + 2)'(4);
          hit  <= 1'b0;
        end
      end
      ST_REST_WAIT: begin
        if (div_done) begin
          if (div_rem == '0) begin
            rest <= div_quo;
            hit  <= 1'b1;
          end else if (!hit) begin
            p  <= p + 1'b1;
            sq <= sq + {1'b0, p, 1'b1};
          end
        end
      end
      ST_ACC_WAIT: begin
        if (div_done) begin
          acc <= acc - div_quo;
          hit <= 1'b0;
          p   <= p + 1'b1;
          sq  <= sq + {1'b0, p, 1'b1};
        end
      end
      ST_TAIL_WAIT: if (div_done) acc <= acc - div_quo;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      totient <= acc;
    end
  end

  // An accepted transaction starts the trial loop next cycle
  a_accept_to_test: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_TEST))
    else $error("accepted transaction did not start the loop");

  // Divider completions arrive only in a wait state
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_REST_WAIT || state == ST_ACC_WAIT ||
                  state == ST_TAIL_WAIT))
    else $error("divider completion outside a wait state");

  // Trial divisor never drops below two while working
  a_p_min: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST) |-> (p >= WIDTH'(2)))
    else $error("trial divisor below two");

  // Totient never exceeds the remaining accumulator bound: acc only shrinks
  a_acc_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && $past(state) != ST_IDLE) |-> (acc <= $past(acc)))
    else $error("accumulator grew during an item");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int WIDTH = 16;

  // Expected totients, oldest first, plus the fault count
  class totient_tracker;
    logic [WIDTH-1:0] pending_totients[$];
    int unsigned faults;

    function new();
      faults = 0;
    endfunction

    // phi(m) by trial division over the distinct prime factors
    static function logic [WIDTH-1:0] phi_of(input logic [WIDTH-1:0] m);
      longint unsigned rest;
      longint unsigned acc;
      longint unsigned p;
      if (m == '0) return '0;
      rest = m;
      acc = m;
      for (p = 2; p * p <= rest; p++) begin
        if (rest % p == 0) begin
          while (rest % p == 0) rest = rest / p;
          acc = acc - acc / p;
        end
      end
      if (rest > 1) acc = acc - acc / rest;
      return acc[WIDTH-1:0];
    endfunction

    // accepted input transaction: queue its totient
    function void note_value(input logic [WIDTH-1:0] m);
      pending_totients = {pending_totients, phi_of(m)};
    endfunction

    // accepted result transaction: compare with the oldest expectation
    function void check_totient(input logic [WIDTH-1:0] got);
      logic [WIDTH-1:0] want;
      if (pending_totients.size() == 0) begin
        $display("%0t: unexpected totient, expected none, actual %0d", $time, got);
        faults++;
      end else begin
        want = pending_totients.pop_front();
        if (got !== want) begin
          $display("%0t: totient mismatch, expected %0d, actual %0d", $time, want, got);
          faults++;
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [WIDTH-1:0] value;
  logic             out_valid;
  logic             out_ready;
  logic [WIDTH-1:0] totient;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  totient_tracker board;

  euler_totient_core #(.WIDTH(WIDTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .totient  (totient)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stalls on the result channel
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) board.note_value(value);
    if (!rst && out_valid && out_ready) board.check_totient(totient);
  end

  // send one value, with a random gap in front of it
  task automatic push_value(input logic [WIDTH-1:0] m);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // random value: mostly small, some full width, some just below the top
  function automatic logic [WIDTH-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return WIDTH'($urandom_range(0, 1023));
    if (r < 85) return WIDTH'($urandom_range(0, 65535));
    return WIDTH'(16'hFFFF - $urandom_range(0, 63));
  endfunction

  logic [WIDTH-1:0] directed_values[$] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd9, 16'd49, 16'd255, 16'd256,
    16'd1024, 16'd30030, 16'd63001, 16'h5555, 16'hAAAA, 16'h8000, 16'd65521,
    16'd65534, 16'hFFFF
  };

  // stimulus and end of run
  initial begin
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    tx_idle_pct = 28;
    rx_idle_pct = 52;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    foreach (directed_values[i]) push_value(directed_values[i]);

    // random part over three idling phases
    for (int n = 0; n < 81; n++) begin
      if (n == 14) begin
        tx_idle_pct = 52;
        rx_idle_pct = 28;
      end else if (n == 48) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      push_value(pick_value());
    end
    in_valid <= 1'b0;

    // drain
    while (board.pending_totients.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (board.faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("%0t: timeout, %0d totients outstanding", $time,
             board.pending_totients.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/etot_pkg.sv
rtl/etot_div.sv
rtl/euler_totient_core.sv
tb/tb_top.sv
